@@ src/sls_pkg.sv @@
package sls_pkg;

   // Widths fixed by the item fields.
   localparam int FIELD_TIME_BITS = 16;
   localparam int TASK_INDEX_BITS = 6;
   localparam int OUT_TIME_BITS   = 23;
   localparam int MAX_TIME_BITS   = 32;

   // Parameter defaults.
   localparam int DEFAULT_MAX_TASKS = 64;
   localparam int DEFAULT_TIME_BITS = 16;

   // Largest time a result can carry; sums saturate here.
   localparam logic [OUT_TIME_BITS-1:0] OUT_TIME_MAX = '1;

   typedef struct packed {
      logic [FIELD_TIME_BITS-1:0] release_time;
      logic [FIELD_TIME_BITS-1:0] process_time;
      logic [FIELD_TIME_BITS-1:0] tail_time;
      logic                       final_task;
   } sls_req_type;

   typedef struct packed {
      logic [TASK_INDEX_BITS-1:0] task_index;
      logic [OUT_TIME_BITS-1:0]   finish_time;
      logic [OUT_TIME_BITS-1:0]   makespan;
      logic                       end_of_schedule;
   } sls_rsp_type;

   // Strobes broadcast from the sequencer to one cell.
   typedef struct packed {
      logic load;
      logic mark;
      logic clear;
   } sls_cell_ctrl_type;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_SWEEP,
      ST_PICK,
      ST_TAIL,
      ST_OUTPUT
   } sls_state_type;

endpackage

@@ src/sls_if.sv @@
interface sls_req_if;
   import sls_pkg::*;
   logic        valid;
   logic        ready;
   sls_req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface sls_rsp_if;
   import sls_pkg::*;
   logic        valid;
   logic        ready;
   sls_rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

@@ src/sls_cell.sv @@
module sls_cell #(
   parameter int TIME_BITS  = sls_pkg::DEFAULT_TIME_BITS,
   parameter int IDX_BITS   = 6,
   parameter int CELL_INDEX = 0
) (
   input  logic                           clock,
   input  logic                           reset,
   input  sls_pkg::sls_cell_ctrl_type     ctrl,
   input  logic [TIME_BITS-1:0]           wr_release,
   input  logic [TIME_BITS-1:0]           wr_process,
   input  logic [TIME_BITS-1:0]           wr_tail,
   input  logic [sls_pkg::OUT_TIME_BITS-1:0] cur_time,
   input  logic                           in_best_valid,
   input  logic [IDX_BITS-1:0]            in_best_idx,
   input  logic [TIME_BITS-1:0]           in_best_tail,
   input  logic [TIME_BITS-1:0]           in_best_proc,
   input  logic                           in_min_valid,
   input  logic [TIME_BITS-1:0]           in_min_rel,
   output logic                           out_best_valid,
   output logic [IDX_BITS-1:0]            out_best_idx,
   output logic [TIME_BITS-1:0]           out_best_tail,
   output logic [TIME_BITS-1:0]           out_best_proc,
   output logic                           out_min_valid,
   output logic [TIME_BITS-1:0]           out_min_rel
);
   import sls_pkg::*;

   localparam int CMP_BITS = (TIME_BITS > OUT_TIME_BITS) ? TIME_BITS : OUT_TIME_BITS;

   logic [TIME_BITS-1:0] rel_ff, proc_ff, tail_ff;
   logic                 used_ff, done_ff;
   logic                 best_valid_ff, min_valid_ff;
   logic [IDX_BITS-1:0]  best_idx_ff;
   logic [TIME_BITS-1:0] best_tail_ff, best_proc_ff, min_rel_ff;

   logic active, is_ready, take, earlier;

   always_comb begin
      active   = used_ff && !done_ff;
      is_ready = active && (CMP_BITS'(rel_ff) <= CMP_BITS'(cur_time));
      // Strict compare keeps the lower load index on equal tails.
      take     = is_ready && (!in_best_valid || (tail_ff > in_best_tail));
      earlier  = active && (!in_min_valid || (rel_ff < in_min_rel));
   end

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         rel_ff  <= wr_release;
         proc_ff <= wr_process;
         tail_ff <= wr_tail;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || ctrl.clear) begin
         used_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         if (ctrl.load) begin
            used_ff <= 1'b1;
         end
         if (ctrl.mark) begin
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         best_valid_ff <= 1'b0;
         min_valid_ff  <= 1'b0;
      end else begin
         best_valid_ff <= take || in_best_valid;
         min_valid_ff  <= earlier || in_min_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         best_idx_ff  <= IDX_BITS'(CELL_INDEX);
         best_tail_ff <= tail_ff;
         best_proc_ff <= proc_ff;
      end else begin
         best_idx_ff  <= in_best_idx;
         best_tail_ff <= in_best_tail;
         best_proc_ff <= in_best_proc;
      end
      min_rel_ff <= earlier ? rel_ff : in_min_rel;
   end

   assign out_best_valid = best_valid_ff;
   assign out_best_idx   = best_idx_ff;
   assign out_best_tail  = best_tail_ff;
   assign out_best_proc  = best_proc_ff;
   assign out_min_valid  = min_valid_ff;
   assign out_min_rel    = min_rel_ff;

endmodule

@@ src/schrage_list_scheduler.sv @@
// Channel   Port       Direction  Moves
// --------  ---------  ---------  -------------------------------------------
// request   req_chan   in         one task: release, process, tail, final mark
// response  rsp_chan   out        one scheduled task: index, finish, makespan
//
// Tasks load at one item per cycle; the item marked final starts the pass.
// Each scheduled task costs a sweep through the cell chain, a pick state,
// a tail state and an output state held until the response is taken; an
// idle time jump adds a sweep and a pick. Reset is synchronous and clears all
// control state; the task stores are not cleared. A stalled response holds
// the block, and no request item is taken while a pass is in progress.
module schrage_list_scheduler #(
   parameter int MAX_TASKS = sls_pkg::DEFAULT_MAX_TASKS,
   parameter int TIME_BITS = sls_pkg::DEFAULT_TIME_BITS
) (
   input logic clock,
   input logic reset,
   sls_req_if.sink   req_chan,
   sls_rsp_if.source rsp_chan
);
   import sls_pkg::*;

   localparam int IDX_BITS  = $clog2(MAX_TASKS);
   localparam int CNT_BITS  = $clog2(MAX_TASKS + 1);
   localparam int WIDE_BITS = ((TIME_BITS > OUT_TIME_BITS) ? TIME_BITS : OUT_TIME_BITS) + 1;

   // The scheduler keeps its state in the FSM registers below and one cell
   // per task slot. During a sweep every cell combines its own task with the
   // candidate handed on by its left neighbor: the ready task with the largest
   // tail and the earliest release among unscheduled tasks. At the end of a
   // sweep the right end of the chain holds both answers for the current time.
   sls_state_type state_ff, state_in;
   logic [CNT_BITS-1:0]      count_ff, count_in;
   logic [CNT_BITS-1:0]      remain_ff, remain_in;
   logic [IDX_BITS-1:0]      sweep_ff, sweep_in;
   logic [OUT_TIME_BITS-1:0] cur_ff, cur_in;
   logic [OUT_TIME_BITS-1:0] max_ff, max_in;
   logic [IDX_BITS-1:0]      pick_idx_ff, pick_idx_in;
   logic [TIME_BITS-1:0]     pick_tail_ff, pick_tail_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   sls_rsp_type              rsp_data_ff, rsp_data_in;

   logic load_en, mark_en, clear_en;
   logic [TIME_BITS-1:0] wr_release, wr_process, wr_tail;

   logic                 chain_best_valid [MAX_TASKS+1];
   logic [IDX_BITS-1:0]  chain_best_idx   [MAX_TASKS+1];
   logic [TIME_BITS-1:0] chain_best_tail  [MAX_TASKS+1];
   logic [TIME_BITS-1:0] chain_best_proc  [MAX_TASKS+1];
   logic                 chain_min_valid  [MAX_TASKS+1];
   logic [TIME_BITS-1:0] chain_min_rel    [MAX_TASKS+1];

   logic [WIDE_BITS-1:0]     finish_wide, deliver_wide, jump_wide;
   logic [OUT_TIME_BITS-1:0] deliver_sat;

   // Time fields are taken in their low TIME_BITS bits.
   assign wr_release = TIME_BITS'(32'(req_chan.payload.release_time));
   assign wr_process = TIME_BITS'(32'(req_chan.payload.process_time));
   assign wr_tail    = TIME_BITS'(32'(req_chan.payload.tail_time));

   // The left end of the chain starts with no candidate.
   assign chain_best_valid[0] = 1'b0;
   assign chain_best_idx[0]   = '0;
   assign chain_best_tail[0]  = '0;
   assign chain_best_proc[0]  = '0;
   assign chain_min_valid[0]  = 1'b0;
   assign chain_min_rel[0]    = '0;

   for (genvar k = 0; k < MAX_TASKS; k++) begin : g_cell
      sls_cell_ctrl_type cell_ctrl;

      always_comb begin
         cell_ctrl.load  = load_en && (count_ff[IDX_BITS-1:0] == IDX_BITS'(k));
         cell_ctrl.mark  = mark_en && (chain_best_idx[MAX_TASKS] == IDX_BITS'(k));
         cell_ctrl.clear = clear_en;
      end

      sls_cell #(
         .TIME_BITS  (TIME_BITS),
         .IDX_BITS   (IDX_BITS),
         .CELL_INDEX (k)
      ) u_cell (
         .clock          (clock),
         .reset          (reset),
         .ctrl           (cell_ctrl),
         .wr_release     (wr_release),
         .wr_process     (wr_process),
         .wr_tail        (wr_tail),
         .cur_time       (cur_ff),
         .in_best_valid  (chain_best_valid[k]),
         .in_best_idx    (chain_best_idx[k]),
         .in_best_tail   (chain_best_tail[k]),
         .in_best_proc   (chain_best_proc[k]),
         .in_min_valid   (chain_min_valid[k]),
         .in_min_rel     (chain_min_rel[k]),
         .out_best_valid (chain_best_valid[k+1]),
         .out_best_idx   (chain_best_idx[k+1]),
         .out_best_tail  (chain_best_tail[k+1]),
         .out_best_proc  (chain_best_proc[k+1]),
         .out_min_valid  (chain_min_valid[k+1]),
         .out_min_rel    (chain_min_rel[k+1])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         count_ff     <= '0;
         remain_ff    <= '0;
         sweep_ff     <= '0;
         cur_ff       <= '0;
         max_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         remain_ff    <= remain_in;
         sweep_ff     <= sweep_in;
         cur_ff       <= cur_in;
         max_ff       <= max_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pick_idx_ff  <= pick_idx_in;
      pick_tail_ff <= pick_tail_in;
      rsp_data_ff  <= rsp_data_in;
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      remain_in    = remain_ff;
      sweep_in     = sweep_ff;
      cur_in       = cur_ff;
      max_in       = max_ff;
      pick_idx_in  = pick_idx_ff;
      pick_tail_in = pick_tail_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      load_en      = 1'b0;
      mark_en      = 1'b0;
      clear_en     = 1'b0;
      req_chan.ready = (state_ff == ST_LOAD);

      finish_wide  = WIDE_BITS'(cur_ff) + WIDE_BITS'(chain_best_proc[MAX_TASKS]);
      jump_wide    = WIDE_BITS'(chain_min_rel[MAX_TASKS]);
      deliver_wide = WIDE_BITS'(cur_ff) + WIDE_BITS'(pick_tail_ff);
      deliver_sat  = (deliver_wide > WIDE_BITS'(OUT_TIME_MAX)) ? OUT_TIME_MAX
                                                              : deliver_wide[OUT_TIME_BITS-1:0];

      case (state_ff)
         ST_LOAD: begin
            if (req_chan.valid) begin
               // A full store drops the task, but a final mark still starts the pass.
               if (count_ff < CNT_BITS'(MAX_TASKS)) begin
                  load_en  = 1'b1;
                  count_in = count_ff + 1'b1;
               end
               if (req_chan.payload.final_task) begin
                  remain_in = count_in;
                  sweep_in  = '0;
                  cur_in    = '0;
                  max_in    = '0;
                  state_in  = ST_SWEEP;
               end
            end
         end
         ST_SWEEP: begin
            sweep_in = sweep_ff + 1'b1;
            if (sweep_ff == IDX_BITS'(MAX_TASKS - 1)) begin
               state_in = ST_PICK;
            end
         end
         ST_PICK: begin
            if (chain_best_valid[MAX_TASKS]) begin
               mark_en      = 1'b1;
               pick_idx_in  = chain_best_idx[MAX_TASKS];
               pick_tail_in = chain_best_tail[MAX_TASKS];
               cur_in       = (finish_wide > WIDE_BITS'(OUT_TIME_MAX)) ? OUT_TIME_MAX
                                                     : finish_wide[OUT_TIME_BITS-1:0];
               remain_in    = remain_ff - 1'b1;
               state_in     = ST_TAIL;
            end else begin
               // Nothing is ready: the machine idles until the earliest release.
               cur_in   = (jump_wide > WIDE_BITS'(OUT_TIME_MAX)) ? OUT_TIME_MAX
                                                     : jump_wide[OUT_TIME_BITS-1:0];
               sweep_in = '0;
               state_in = ST_SWEEP;
            end
         end
         ST_TAIL: begin
            if (deliver_sat > max_ff) begin
               max_in = deliver_sat;
            end
            rsp_data_in.task_index      = TASK_INDEX_BITS'(pick_idx_ff);
            rsp_data_in.finish_time     = cur_ff;
            rsp_data_in.makespan        = (deliver_sat > max_ff) ? deliver_sat : max_ff;
            rsp_data_in.end_of_schedule = (remain_ff == '0);
            rsp_valid_in = 1'b1;
            state_in     = ST_OUTPUT;
         end
         ST_OUTPUT: begin
            if (rsp_chan.ready) begin
               rsp_valid_in = 1'b0;
               if (remain_ff == '0) begin
                  // The pass is over: the next item begins a new task set.
                  clear_en = 1'b1;
                  count_in = '0;
                  cur_in   = '0;
                  max_in   = '0;
                  state_in = ST_LOAD;
               end else begin
                  sweep_in = '0;
                  state_in = ST_SWEEP;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_data_ff;

   // The block never offers a result while it is taking tasks.
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_chan.ready && rsp_chan.valid))
      else $error("request ready while a result is pending");

   // After the last result of a pass is taken, the block loads again.
   a_back_to_load: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.ready && rsp_chan.payload.end_of_schedule)
      |=> req_chan.ready)
      else $error("block did not return to loading after the schedule ended");

   // The end mark agrees with the count of tasks still to schedule.
   a_end_mark: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.payload.end_of_schedule == (remain_ff == '0)))
      else $error("end of schedule mark disagrees with remaining count");

   // Within a pass the makespan only grows from one result to the next.
   a_makespan_grows: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_chan.valid) |-> (rsp_chan.payload.makespan >= max_ff))
      else $error("makespan fell below the running maximum");

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps

// Self-checking bench for the Schrage list scheduler.
//
// An initial block builds a queue of task items: a short directed list of
// task sets first, then random task sets. A clocked driver feeds that queue
// into the request channel in bursts with random gaps. Every accepted task
// also goes into a behavioral copy of the scheduler kept in this file. When
// the task marked final is accepted, that copy runs Schrage's rule over the
// loaded set and queues the scheduled tasks it expects, in schedule order.
// A clocked monitor takes each response item and compares it field by field
// with the oldest expected entry. The response side stalls on a repeating
// pattern of its own, so both sides see back pressure at every phase.
module testbench;
   import sls_pkg::*;

   localparam int MAX_TASKS      = DEFAULT_MAX_TASKS;
   localparam int WATCHDOG_LIMIT = 4000;
   // A task costs sweep, pick, tail and output states; a jump, sweep and pick.
   localparam int DRAIN_CYCLES   = 4 * MAX_TASKS + 50;
   localparam int RANDOM_ITEMS   = 230;

   logic clock = 1'b0;
   logic reset;

   sls_req_if req_chan ();
   sls_rsp_if rsp_chan ();

   schrage_list_scheduler dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always #5 clock = ~clock;

   // Stimulus waiting to be driven, and the scheduled tasks still expected.
   sls_req_type task_items[$];
   sls_rsp_type expected_slots[$];

   // Behavioral copy of the task store for the set being loaded.
   logic [FIELD_TIME_BITS-1:0] model_release [MAX_TASKS];
   logic [FIELD_TIME_BITS-1:0] model_process [MAX_TASKS];
   logic [FIELD_TIME_BITS-1:0] model_tail    [MAX_TASKS];
   int                         model_count;

   int error_count;
   int idle_cycles;
   int burst_left;
   int gap_left;
   logic [7:0] stall_phase;

   task automatic report_mismatch(string what, longint got, longint want);
      $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
      error_count++;
   endtask

   // Completion times saturate at the largest value a result can carry.
   function automatic logic [OUT_TIME_BITS-1:0] saturating_add(
      logic [OUT_TIME_BITS-1:0] a, logic [FIELD_TIME_BITS-1:0] b);
      logic [OUT_TIME_BITS:0] sum;
      sum = {1'b0, a} + b;
      return sum[OUT_TIME_BITS] ? OUT_TIME_MAX : sum[OUT_TIME_BITS-1:0];
   endfunction

   // Runs Schrage's rule over the loaded set and queues one expected
   // response per task, in the order the machine would run them.
   task automatic schedule_loaded_set();
      logic [MAX_TASKS-1:0]       scheduled;
      logic [OUT_TIME_BITS-1:0]   now;
      logic [OUT_TIME_BITS-1:0]   cmax;
      logic [OUT_TIME_BITS-1:0]   delivered;
      logic [FIELD_TIME_BITS-1:0] best_tail;
      logic [FIELD_TIME_BITS-1:0] earliest;
      logic                       seen;
      int                         remaining;
      int                         pick;
      sls_rsp_type                slot;
      scheduled = '0;
      now       = '0;
      cmax      = '0;
      remaining = model_count;
      while (remaining > 0) begin
         pick      = -1;
         best_tail = '0;
         // Strictly greater keeps the lowest load index on equal tails.
         for (int i = 0; i < model_count; i++) begin
            if (!scheduled[i] && model_release[i] <= now &&
                (pick < 0 || model_tail[i] > best_tail)) begin
               pick      = i;
               best_tail = model_tail[i];
            end
         end
         if (pick < 0) begin
            // Machine idle: jump to the earliest pending release.
            seen     = 1'b0;
            earliest = '0;
            for (int i = 0; i < model_count; i++) begin
               if (!scheduled[i] && (!seen || model_release[i] < earliest)) begin
                  earliest = model_release[i];
                  seen     = 1'b1;
               end
            end
            now = OUT_TIME_BITS'(earliest);
         end else begin
            scheduled[pick] = 1'b1;
            remaining--;
            now       = saturating_add(now, model_process[pick]);
            delivered = saturating_add(now, model_tail[pick]);
            if (delivered > cmax) begin
               cmax = delivered;
            end
            slot.task_index      = TASK_INDEX_BITS'(pick);
            slot.finish_time     = now;
            slot.makespan        = cmax;
            slot.end_of_schedule = (remaining == 0);
            expected_slots.insert(expected_slots.size(), slot);
         end
      end
   endtask

   // Loads one accepted task; a full store drops it, but a final mark
   // still schedules whatever is stored and then empties the store.
   task automatic load_task(sls_req_type item);
      if (model_count < MAX_TASKS) begin
         model_release[model_count] = item.release_time;
         model_process[model_count] = item.process_time;
         model_tail[model_count]    = item.tail_time;
         model_count++;
      end
      if (item.final_task) begin
         schedule_loaded_set();
         model_count = 0;
      end
   endtask

   task automatic add_task(int rel, int proc, int tail, bit last);
      sls_req_type item;
      item.release_time = FIELD_TIME_BITS'(rel);
      item.process_time = FIELD_TIME_BITS'(proc);
      item.tail_time    = FIELD_TIME_BITS'(tail);
      item.final_task   = last;
      task_items.insert(task_items.size(), item);
   endtask

   // One random task set. The value style varies per set: full-range fields
   // exercise every bit, clustered releases with few distinct tails force
   // tie breaks among many ready tasks, sparse releases with short jobs
   // produce idle time jumps, and full-range times get tails below eight.
   task automatic add_random_set(int count);
      int style;
      int rel_span;
      style    = $urandom_range(0, 3);
      rel_span = $urandom_range(0, 400);
      for (int n = 0; n < count; n++) begin
         case (style)
            0: begin
               add_task($urandom_range(0, 65535), $urandom_range(0, 65535),
                        $urandom_range(0, 65535), n == count - 1);
            end
            1: begin
               add_task($urandom_range(0, rel_span), $urandom_range(0, 60),
                        1000 * $urandom_range(0, 3), n == count - 1);
            end
            2: begin
               add_task($urandom_range(0, 65535), $urandom_range(0, 200),
                        $urandom_range(0, 65535), n == count - 1);
            end
            default: begin
               add_task($urandom_range(0, 65535), $urandom_range(0, 65535),
                        $urandom_range(0, 7), n == count - 1);
            end
         endcase
      end
   endtask

   // Request driver: bursts of random length separated by random gaps.
   // A presented item is held until the block takes it.
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
         burst_left     <= 0;
         gap_left       <= 0;
      end else if (req_chan.valid && !req_chan.ready) begin
         // Hold the current item.
      end else if (gap_left != 0) begin
         req_chan.valid <= 1'b0;
         gap_left       <= gap_left - 1;
      end else if (task_items.size() != 0) begin
         req_chan.valid   <= 1'b1;
         req_chan.payload <= task_items.pop_front();
         if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 16);
            gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
         end else begin
            burst_left <= burst_left - 1;
         end
      end else begin
         req_chan.valid <= 1'b0;
      end
   end

   // Response stall pattern: a stretch that is always ready, a stretch of
   // random stalls, then alternating equal runs of stalled and ready.
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         stall_phase    <= '0;
      end else begin
         stall_phase <= stall_phase + 8'd1;
         if (stall_phase < 8'd64) begin
            rsp_chan.ready <= 1'b1;
         end else if (stall_phase < 8'd160) begin
            rsp_chan.ready <= ($urandom_range(0, 3) != 0);
         end else begin
            rsp_chan.ready <= stall_phase[4];
         end
      end
   end

   // Feed every accepted task into the behavioral copy.
   always @(posedge clock) begin
      if (!reset && req_chan.valid && req_chan.ready) begin
         load_task(req_chan.payload);
      end
   end

   // Response monitor: compare with the oldest expectation.
   always @(posedge clock) begin
      sls_rsp_type want;
      sls_rsp_type got;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got = rsp_chan.payload;
         if (expected_slots.size() == 0) begin
            $display("%0t: response item with no scheduled task pending, task_index %0d",
                     $realtime, got.task_index);
            error_count++;
         end else begin
            want = expected_slots.pop_front();
            if (got.task_index !== want.task_index) begin
               report_mismatch("task_index", got.task_index, want.task_index);
            end
            if (got.finish_time !== want.finish_time) begin
               report_mismatch("finish_time", got.finish_time, want.finish_time);
            end
            if (got.makespan !== want.makespan) begin
               report_mismatch("makespan", got.makespan, want.makespan);
            end
            if (got.end_of_schedule !== want.end_of_schedule) begin
               report_mismatch("end_of_schedule", got.end_of_schedule,
                               want.end_of_schedule);
            end
         end
      end
   end

   // Watchdog: too long without any item moving on either channel.
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) ||
          (rsp_chan.valid && rsp_chan.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no item moved for %0d cycles", $realtime, WATCHDOG_LIMIT);
         $display("TB_ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int random_items;
      int big_set_at;
      int set_number;
      int set_size;

      reset            = 1'b1;
      req_chan.valid   = 1'b0;
      req_chan.payload = '0;
      rsp_chan.ready   = 1'b0;
      error_count      = 0;
      idle_cycles      = 0;
      model_count      = 0;

      // Directed sets.
      // A lone task at the field maxima: the clock jumps to its release.
      add_task(65535, 65535, 65535, 1);
      // A lone task with every field zero.
      add_task(0, 0, 0, 1);
      // All released at once; equal tails run in load order, the larger
      // tail first, a zero-length job in between.
      add_task(0, 5, 100, 0);
      add_task(0, 0, 100, 0);
      add_task(0, 7, 300, 0);
      add_task(0, 3, 100, 1);
      // Sparse releases leave the machine idle between jobs.
      add_task(1000, 10, 5, 0);
      add_task(0, 20, 50, 0);
      add_task(5000, 1, 65535, 0);
      add_task(30, 0, 0, 1);
      // Two later releases with equal tails queue behind a long first job.
      add_task(0, 100, 1, 0);
      add_task(50, 10, 900, 0);
      add_task(60, 10, 900, 1);
      // Alternating bit patterns.
      add_task(16'hAAAA, 16'h5555, 16'hAAAA, 0);
      add_task(16'h5555, 16'hAAAA, 16'h5555, 1);

      // Random sets, mostly small. One set overfills the store so that the
      // tasks past its capacity are dropped and the final mark still counts.
      random_items = 0;
      set_number   = 0;
      big_set_at   = $urandom_range(1, 8);
      while (random_items < RANDOM_ITEMS) begin
         if (set_number == big_set_at) begin
            set_size = $urandom_range(MAX_TASKS + 2, MAX_TASKS + 6);
         end else begin
            set_size = $urandom_range(1, 10);
         end
         add_random_set(set_size);
         random_items += set_size;
         set_number++;
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Wait until every task has been taken, then until every scheduled
      // task has come back, then a little longer to catch strays.
      while (task_items.size() != 0 || req_chan.valid) begin
         @(posedge clock);
      end
      while (expected_slots.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (expected_slots.size() != 0) begin
         $display("%0d scheduled tasks never came back", expected_slots.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
